// ===== rtl/core/tbf_pkg.sv =====
// ----------------------------------------------------------------------------
// tbf_pkg
// shared types and constants of the transparent blit engine
// ----------------------------------------------------------------------------
package tbf_pkg;

  localparam int COORD_W     = 11;
  localparam int PIXEL_W     = 32;
  localparam int ADDR_W      = 20;
  localparam int COLOR_W     = 24;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hff;
  localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

  // register indexes of the configuration port
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DEST_X,
    REG_DEST_Y,
    REG_RECT_WIDTH,
    REG_RECT_HEIGHT,
    REG_FB_WIDTH,
    REG_FLIP_VERTICAL,
    REG_FILL_MODE,
    REG_FILL_COLOR
  } cfg_reg_t;

  typedef struct packed {
    logic [COORD_W-1:0] dest_x;
    logic [COORD_W-1:0] dest_y;
    logic [COORD_W-1:0] rect_width;
    logic [COORD_W-1:0] rect_height;
    logic [COORD_W-1:0] fb_width;
    logic               flip_vertical;
    logic               fill_mode;
    logic [COLOR_W-1:0] fill_color;
  } cfg_t;

  // 0xRRGGBB colour to opaque pixel, red in the low byte
  function automatic logic [PIXEL_W-1:0] fill_pixel(input logic [COLOR_W-1:0] color);
    fill_pixel = {ALPHA_OPAQUE, color[7:0], color[15:8], color[23:16]};
  endfunction

endpackage

// ===== rtl/core/tbf_cfg_if.sv =====
// ----------------------------------------------------------------------------
// tbf_cfg_if
// configuration write channel: register index and write data
// ----------------------------------------------------------------------------
interface tbf_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [tbf_pkg::CFG_INDEX_W-1:0]  index;
  logic [tbf_pkg::CFG_DATA_W-1:0]   data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/core/tbf_src_if.sv =====
// ----------------------------------------------------------------------------
// tbf_src_if
// source pixel channel
// ----------------------------------------------------------------------------
interface tbf_src_if;
  logic                         valid;
  logic                         ready;
  logic                         first;
  logic [tbf_pkg::PIXEL_W-1:0]  src_pixel;

  modport source(output valid, first, src_pixel, input ready);
  modport sink(input valid, first, src_pixel, output ready);
endinterface

// ===== rtl/core/tbf_dst_if.sv =====
// ----------------------------------------------------------------------------
// tbf_dst_if
// framebuffer write channel
// ----------------------------------------------------------------------------
interface tbf_dst_if;
  logic                         valid;
  logic                         ready;
  logic [tbf_pkg::ADDR_W-1:0]   write_addr;
  logic [tbf_pkg::PIXEL_W-1:0]  write_data;

  modport source(output valid, write_addr, write_data, input ready);
  modport sink(input valid, write_addr, write_data, output ready);
endinterface

// ===== rtl/core/transparent_blit_with_fill.sv =====
// ----------------------------------------------------------------------------
// transparent_blit_with_fill
// a written item passes stage 1, stage 2 and the dst output register before it leaves the dst port
// throughput: one src item per cycle, dst stalls back up through a 3-deep pipeline
// items with no write (clear alpha outside fill mode, bad sizes, off canvas, outside the rectangle) just vanish
// reset: sync rst clears counters, pipeline valids and loads register defaults
// ----------------------------------------------------------------------------
module transparent_blit_with_fill #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_ROWS  = 1024
) (
  input  logic       clk,
  input  logic       rst,
  tbf_cfg_if.sink    cfg,
  tbf_src_if.sink    src,
  tbf_dst_if.source  dst
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int MAXCR = (CW > RW) ? CW : RW;
  // compare width: holds the size limits, 11-bit registers and a sign bit
  localparam int CMPW  = ((MAXCR > tbf_pkg::COORD_W) ? MAXCR : tbf_pkg::COORD_W) + 2;
  // address arithmetic width before wrapping to the address port
  localparam int SUMW  = RW + tbf_pkg::COORD_W + 2;

  // configuration registers
  tbf_pkg::cfg_t cfg_r;

  tbf_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (cfg_r)
  );

  // static decode of the geometry, config must only change while idle (the block does not enforce it)
  logic [CMPW-1:0] w_src;
  logic [CMPW-1:0] h_src;
  logic [CMPW-1:0] w_dst;
  logic [CMPW-1:0] lim_w;
  logic [CMPW-1:0] lim_h;
  logic [CMPW-1:0] x_max;
  logic [CMPW-1:0] dest_x_ext;
  logic [CMPW-1:0] dest_y_ext;
  logic [tbf_pkg::COORD_W-1:0] x_clamped;
  logic sizes_ok;
  logic fits;

  always_comb begin
    w_src    = CMPW'(cfg_r.rect_width);
    h_src    = CMPW'(cfg_r.rect_height);
    w_dst    = CMPW'(cfg_r.fb_width);
    sizes_ok = (w_src != '0) && (w_src <= CMPW'(MAX_WIDTH)) &&
               (w_dst != '0) && (w_dst <= CMPW'(MAX_WIDTH)) &&
               (h_src != '0) && (h_src <= CMPW'(MAX_ROWS));
    fits     = sizes_ok && (w_src <= w_dst);
    // when sizes are bad the counters wrap at the maximum geometry
    lim_w    = sizes_ok ? w_src : CMPW'(MAX_WIDTH);
    lim_h    = sizes_ok ? h_src : CMPW'(MAX_ROWS);
    x_max    = w_dst - w_src;
    dest_x_ext = {{(CMPW-tbf_pkg::COORD_W){cfg_r.dest_x[tbf_pkg::COORD_W-1]}}, cfg_r.dest_x};
    dest_y_ext = {{(CMPW-tbf_pkg::COORD_W){cfg_r.dest_y[tbf_pkg::COORD_W-1]}}, cfg_r.dest_y};
    // left column clamped into [0, fb_width - rect_width]
    if (cfg_r.dest_x[tbf_pkg::COORD_W-1]) begin
      x_clamped = '0;
    end else if (dest_x_ext > x_max) begin
      x_clamped = tbf_pkg::COORD_W'(x_max);
    end else begin
      x_clamped = cfg_r.dest_x;
    end
  end

  // pipeline enables, a stage moves when it is empty or the next one moves
  logic s1_valid;
  logic s2_valid;
  logic dst_valid;
  logic en1;
  logic en2;
  logic en3;

  assign en3       = !dst_valid || dst.ready;
  assign en2       = !s2_valid || en3;
  assign en1       = !s1_valid || en2;
  assign src.ready = en1;
  assign dst.valid = dst_valid;

  logic src_take;
  assign src_take = src.valid && en1;

  // raster counters, advanced as each item is taken
  logic [CW-1:0]   col_count;
  logic [RW-1:0]   row_count;
  logic [CW-1:0]   col_count_next;
  logic [RW-1:0]   row_count_next;
  logic [CW-1:0]   cur_col;
  logic [RW-1:0]   cur_row;
  logic [CMPW-1:0] col_inc;
  logic [CMPW-1:0] row_inc;

  always_comb begin
    // first restarts the blit at this very item
    cur_col = src.first ? '0 : col_count;
    cur_row = src.first ? '0 : row_count;
    col_inc = CMPW'(cur_col) + CMPW'(1);
    row_inc = CMPW'(cur_row) + CMPW'(1);
    if (col_inc >= lim_w) begin
      col_count_next = '0;
      // wrap after the last row so extra items repeat the blit
      row_count_next = (row_inc >= lim_h) ? '0 : RW'(row_inc);
    end else begin
      col_count_next = CW'(col_inc);
      row_count_next = cur_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (src_take) begin
      col_count <= col_count_next;
      row_count <= row_count_next;
    end
  end

  // stage 1: the taken item and its raster position
  logic [CW-1:0]                s1_col;
  logic [RW-1:0]                s1_row;
  logic [tbf_pkg::PIXEL_W-1:0]  s1_pixel;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en1) begin
      s1_valid <= src.valid;
    end
    if (src_take) begin
      s1_col   <= cur_col;
      s1_row   <= cur_row;
      s1_pixel <= src.src_pixel;
    end
  end

  // stage 2 logic: target row, visibility and pixel data
  logic [CMPW-1:0]              src_row;
  logic [CMPW-1:0]              draw_y;
  logic                         in_rect;
  logic                         row_ok;
  logic                         opaque;
  logic                         s2_keep;
  logic [tbf_pkg::PIXEL_W-1:0]  s2_data_next;

  always_comb begin
    // a counter beyond a shrunk size gets no write
    in_rect = (CMPW'(s1_col) < w_src) && (CMPW'(s1_row) < h_src);
    src_row = cfg_r.flip_vertical ? (h_src - CMPW'(1) - CMPW'(s1_row)) : CMPW'(s1_row);
    draw_y  = dest_y_ext + src_row;
    // rows above the canvas or at or past MAX_ROWS are dropped
    row_ok  = !draw_y[CMPW-1] && (draw_y < CMPW'(MAX_ROWS));
    opaque  = s1_pixel[tbf_pkg::PIXEL_W-1 -: 8] != tbf_pkg::ALPHA_CLEAR;
    s2_keep = s1_valid && fits && in_rect && row_ok && (cfg_r.fill_mode || opaque);
    s2_data_next = cfg_r.fill_mode ? tbf_pkg::fill_pixel(cfg_r.fill_color) : s1_pixel;
  end

  logic [RW-1:0]                s2_row;
  logic [CW-1:0]                s2_col;
  logic [tbf_pkg::COORD_W-1:0]  s2_x;
  logic [tbf_pkg::PIXEL_W-1:0]  s2_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en2) begin
      s2_valid <= s2_keep;
    end
    if (en2) begin
      s2_row  <= RW'(draw_y);
      s2_col  <= s1_col;
      s2_x    <= x_clamped;
      s2_data <= s2_data_next;
    end
  end

  // stage 3: row * width + x + col, wrapped to the address width
  logic [SUMW-1:0] addr_full;

  assign addr_full = SUMW'(s2_row) * SUMW'(cfg_r.fb_width) + SUMW'(s2_x) + SUMW'(s2_col);

  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else if (en3) begin
      dst_valid <= s2_valid;
    end
    if (en3 && s2_valid) begin
      dst.write_addr <= tbf_pkg::ADDR_W'(addr_full);
      dst.write_data <= s2_data;
    end
  end

`ifndef NO_ASSERTIONS
  // a write never carries a clear pixel
  a_no_clear_write: assert property (@(posedge clk) disable iff (rst)
    dst.valid |-> dst.write_data[tbf_pkg::PIXEL_W-1 -: 8] != tbf_pkg::ALPHA_CLEAR)
    else $error("write with clear alpha");

  // counters stay inside the maximum geometry
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    CMPW'(col_count) < CMPW'(MAX_WIDTH))
    else $error("column counter out of range");

  a_row_range: assert property (@(posedge clk) disable iff (rst)
    CMPW'(row_count) < CMPW'(MAX_ROWS))
    else $error("row counter out of range");

  // a pending write in stage 2 is not lost while the output stalls
  a_s2_hold: assert property (@(posedge clk) disable iff (rst)
    s2_valid && !en3 |=> s2_valid)
    else $error("stage 2 item dropped under stall");

  // an empty input stage always takes an item
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> src.ready)
    else $error("input stalled with empty stage 1");
`endif

endmodule

// ===== rtl/core/tbf_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// tbf_cfg_regs
// configuration register file, always ready
// ----------------------------------------------------------------------------
module tbf_cfg_regs (
  input  logic            clk,
  input  logic            rst,
  tbf_cfg_if.sink         cfg,
  output tbf_pkg::cfg_t   regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.dest_x        <= '0;
      regs.dest_y        <= '0;
      regs.rect_width    <= tbf_pkg::COORD_W'(1);
      regs.rect_height   <= tbf_pkg::COORD_W'(1);
      regs.fb_width      <= tbf_pkg::COORD_W'(320);
      regs.flip_vertical <= 1'b0;
      regs.fill_mode     <= 1'b0;
      regs.fill_color    <= '0;
    end else if (cfg.valid) begin
      case (tbf_pkg::cfg_reg_t'(cfg.index))
        tbf_pkg::REG_DEST_X:        regs.dest_x        <= cfg.data[tbf_pkg::COORD_W-1:0];
        tbf_pkg::REG_DEST_Y:        regs.dest_y        <= cfg.data[tbf_pkg::COORD_W-1:0];
        tbf_pkg::REG_RECT_WIDTH:    regs.rect_width    <= cfg.data[tbf_pkg::COORD_W-1:0];
        tbf_pkg::REG_RECT_HEIGHT:   regs.rect_height   <= cfg.data[tbf_pkg::COORD_W-1:0];
        tbf_pkg::REG_FB_WIDTH:      regs.fb_width      <= cfg.data[tbf_pkg::COORD_W-1:0];
        tbf_pkg::REG_FLIP_VERTICAL: regs.flip_vertical <= cfg.data[0];
        tbf_pkg::REG_FILL_MODE:     regs.fill_mode     <= cfg.data[0];
        tbf_pkg::REG_FILL_COLOR:    regs.fill_color    <= cfg.data[tbf_pkg::COLOR_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule
